>>> sv/keyframe_curve_evaluator_assert.svh
// Assertion macros for the keyframe curve evaluator checker
`ifndef KEYFRAME_CURVE_EVALUATOR_ASSERT_SVH
`define KEYFRAME_CURVE_EVALUATOR_ASSERT_SVH

// same-cycle implication, disabled in reset
`define KFE_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("keyframe curve evaluator check failed");

// next-cycle implication, disabled in reset
`define KFE_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("keyframe curve evaluator check failed");

`endif

>>> sv/kfe_pkg.sv
// Package: types, constants and state codes of the keyframe curve evaluator
`timescale 1ns / 1ps
package kfe_pkg;

    localparam int MAX_KEYS   = 32;
    localparam int FRAC_BITS  = 16;
    localparam int SLOT_W     = $clog2(MAX_KEYS);
    localparam int CNT_W      = $clog2(MAX_KEYS + 1);

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_EVAL  = 1'b1;

    localparam logic [1:0] KIND_CONST  = 2'd0;
    localparam logic [1:0] KIND_LINEAR = 2'd1;
    localparam logic [1:0] KIND_CUBIC  = 2'd2;

    typedef struct packed {
        logic               cmd;
        logic [4:0]         key_slot;
        logic signed [31:0] key_time;
        logic [1:0]         key_kind;
        logic signed [31:0] key_value;
        logic signed [31:0] key_slope_in;
        logic signed [31:0] key_slope_out;
        logic signed [31:0] query_time;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] curve_value;
        logic               past_end;
        logic               saturated;
    } t_out_item;

    typedef struct packed {
        logic signed [31:0] key_time;
        logic [1:0]         key_kind;
        logic signed [31:0] key_value;
        logic signed [31:0] key_slope_in;
        logic signed [31:0] key_slope_out;
    } t_key;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_DIV,
        ST_MUL_LIN,
        ST_MUL_AU,
        ST_MUL_BT,
        ST_MUL_TU,
        ST_LOAD_W,
        ST_MUL_HW,
        ST_ADD_HW,
        ST_DONE
    } t_state;

endpackage

>>> sv/kfe_if.sv
// Channel interfaces: input items, result items and configuration writes
`timescale 1ns / 1ps
interface kfe_in_if import kfe_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface kfe_out_if import kfe_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface kfe_cfg_if ();
    logic       valid;
    logic       ready;
    logic [5:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> sv/keyframe_curve_evaluator.sv
// Top level: keyframe curve evaluator with scan, divider and shared multiplier
// A write item stores one keyframe and the block stays ready.
// An evaluate item scans the table key by key (memory read, then compare),
// then runs a restoring division for the 16-bit blend fraction and up to
// seven steps on one shared 37x18 multiplier for the cubic form.
// The input is not ready while an evaluation is under way; one finished
// result waits in the output register. keys_in_use resets to 1.
`timescale 1ns / 1ps
module keyframe_curve_evaluator import kfe_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    kfe_in_if.sink     i_in,
    kfe_out_if.source  o_out,
    kfe_cfg_if.sink    i_cfg
);
    t_state r_state, n_state;

    logic [5:0]        r_keys;
    logic [CNT_W-1:0]  r_idx;
    logic [CNT_W-1:0]  w_n;
    logic signed [31:0] r_q;
    t_key              r_prev;
    logic signed [31:0] r_first_value;
    logic              r_past;

    logic signed [31:0] r_lv;
    logic signed [32:0] r_d;
    logic [1:0]        r_kind;
    logic signed [31:0] r_sin;
    logic signed [31:0] r_sout;
    logic signed [33:0] r_a;
    logic signed [33:0] r_b;
    logic [32:0]       r_rem;
    logic [32:0]       r_den;
    logic [3:0]        r_div_cnt;
    logic [15:0]       r_t;
    logic [16:0]       r_u;
    logic [15:0]       r_w;
    logic signed [36:0] r_h;
    logic signed [54:0] r_hsum;
    logic signed [54:0] r_prod;
    logic signed [63:0] r_acc;

    logic              r_out_valid;
    t_out_item         r_out_item;

    t_key              w_rd;
    logic              w_in_acc;
    logic              w_load_out;
    logic signed [36:0] w_ma;
    logic signed [17:0] w_mb;
    logic [33:0]       w_rem2;
    logic              w_qbit;
    logic [CNT_W-1:0]  w_idx_nx;
    t_key              w_wr_key;

    assign w_in_acc = i_in.valid && i_in.ready;
    assign w_n = (r_keys == '0) ? CNT_W'(1) :
                 ((r_keys > 6'(MAX_KEYS)) ? CNT_W'(MAX_KEYS) : CNT_W'(r_keys));
    assign w_idx_nx = r_idx + CNT_W'(1);
    assign w_rem2 = {r_rem, 1'b0};
    assign w_qbit = (w_rem2 >= {1'b0, r_den});

    assign w_wr_key = '{key_time: i_in.data.key_time, key_kind: i_in.data.key_kind,
                        key_value: i_in.data.key_value,
                        key_slope_in: i_in.data.key_slope_in,
                        key_slope_out: i_in.data.key_slope_out};

    kfe_key_ram u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_in_acc && (i_in.data.cmd == CMD_WRITE)),
        .i_wr_addr (i_in.data.key_slot),
        .i_wr_data (w_wr_key),
        .i_rd_addr (r_idx[SLOT_W-1:0]),
        .o_rd_data (w_rd)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_in_acc && (i_in.data.cmd == CMD_EVAL)) n_state = ST_SCAN_RD;
            end
            ST_SCAN_RD: n_state = ST_SCAN_CHK;
            ST_SCAN_CHK: begin
                if (w_rd.key_time == r_q) begin
                    n_state = ST_DONE;
                end else if (w_rd.key_time > r_q) begin
                    n_state = (r_idx == '0) ? ST_DONE : ST_DIV;
                end else if (w_idx_nx == w_n) begin
                    n_state = ST_DONE;
                end else begin
                    n_state = ST_SCAN_RD;
                end
            end
            ST_DIV: begin
                if (r_div_cnt == 4'd15) begin
                    n_state = (r_kind inside {KIND_LINEAR, KIND_CUBIC}) ?
                              ST_MUL_LIN : ST_DONE;
                end
            end
            ST_MUL_LIN: n_state = ST_MUL_AU;
            ST_MUL_AU:  n_state = (r_kind == KIND_CUBIC) ? ST_MUL_BT : ST_DONE;
            ST_MUL_BT:  n_state = ST_MUL_TU;
            ST_MUL_TU:  n_state = ST_LOAD_W;
            ST_LOAD_W:  n_state = ST_MUL_HW;
            ST_MUL_HW:  n_state = ST_ADD_HW;
            ST_ADD_HW:  n_state = ST_DONE;
            ST_DONE: begin
                if (!r_out_valid || o_out.ready) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        w_ma = '0;
        w_mb = '0;
        w_load_out = 1'b0;
        case (r_state)
            ST_MUL_LIN: begin
                w_ma = 37'(r_d);
                w_mb = $signed({2'b00, r_t});
            end
            ST_MUL_AU: begin
                w_ma = 37'(r_a);
                w_mb = $signed({1'b0, r_u});
            end
            ST_MUL_BT: begin
                w_ma = 37'(r_b);
                w_mb = $signed({2'b00, r_t});
            end
            ST_MUL_TU: begin
                w_ma = $signed({21'd0, r_t});
                w_mb = $signed({1'b0, r_u});
            end
            ST_MUL_HW: begin
                w_ma = r_h;
                w_mb = $signed({2'b00, r_w});
            end
            ST_DONE: w_load_out = !r_out_valid || o_out.ready;
            default: w_load_out = 1'b0;
        endcase
    end

    assign i_in.ready  = (r_state == ST_IDLE);
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_keys      <= 6'd1;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg.valid) r_keys <= i_cfg.data;
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= w_ma * w_mb;
        case (r_state)
            ST_IDLE: begin
                r_q    <= i_in.data.query_time;
                r_idx  <= '0;
                r_past <= 1'b0;
            end
            ST_SCAN_CHK: begin
                if (r_idx == '0) r_first_value <= w_rd.key_value;
                r_prev <= w_rd;
                if (w_rd.key_time == r_q) begin
                    r_acc <= 64'(w_rd.key_value);
                end else if (w_rd.key_time > r_q) begin
                    r_acc     <= 64'(r_idx == '0 ? w_rd.key_value : r_prev.key_value);
                    r_lv      <= r_prev.key_value;
                    r_d       <= 33'(w_rd.key_value) - 33'(r_prev.key_value);
                    r_kind    <= r_prev.key_kind;
                    r_sin     <= r_prev.key_slope_in;
                    r_sout    <= r_prev.key_slope_out;
                    r_rem     <= 33'(33'(r_q) - 33'(r_prev.key_time));
                    r_den     <= 33'(33'(w_rd.key_time) - 33'(r_prev.key_time));
                    r_div_cnt <= '0;
                    r_t       <= '0;
                end else begin
                    r_idx <= w_idx_nx;
                    if (w_idx_nx == w_n) begin
                        r_acc  <= 64'(r_idx == '0 ? w_rd.key_value : r_first_value);
                        r_past <= 1'b1;
                    end
                end
            end
            ST_DIV: begin
                r_rem     <= w_qbit ? 33'(w_rem2 - {1'b0, r_den}) : w_rem2[32:0];
                r_t       <= {r_t[14:0], w_qbit};
                r_div_cnt <= r_div_cnt + 4'd1;
            end
            ST_MUL_LIN: begin
                r_u <= 17'h10000 - {1'b0, r_t};
                r_a <= 34'(r_sin) - 34'(r_d);
                r_b <= 34'(r_d) - 34'(r_sout);
            end
            ST_MUL_AU: r_acc <= 64'(r_lv) + 64'(r_prod >>> FRAC_BITS);
            ST_MUL_BT: r_hsum <= r_prod;
            ST_MUL_TU: r_h <= 37'((r_hsum + r_prod) >>> FRAC_BITS);
            ST_LOAD_W: r_w <= r_prod[31:16];
            ST_ADD_HW: r_acc <= r_acc + 64'(r_prod >>> FRAC_BITS);
            default: begin
            end
        endcase
        if (w_load_out) begin
            if (r_acc > 64'sh7FFF_FFFF) begin
                r_out_item.curve_value <= 32'sh7FFF_FFFF;
                r_out_item.saturated   <= 1'b1;
            end else if (r_acc < -64'sh8000_0000) begin
                r_out_item.curve_value <= 32'sh8000_0000;
                r_out_item.saturated   <= 1'b1;
            end else begin
                r_out_item.curve_value <= r_acc[31:0];
                r_out_item.saturated   <= 1'b0;
            end
            r_out_item.past_end <= r_past;
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out_item;
endmodule

>>> sv/kfe_key_ram.sv
// Keyframe table memory: one write port, one registered read port
`timescale 1ns / 1ps
module kfe_key_ram import kfe_pkg::*; (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [SLOT_W-1:0] i_wr_addr,
    input  t_key              i_wr_data,
    input  logic [SLOT_W-1:0] i_rd_addr,
    output t_key              o_rd_data
);
    t_key r_mem [MAX_KEYS];
    t_key r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;
endmodule

>>> sv/kfe_checker.sv
// Port-level checker for the keyframe curve evaluator, bound to the top level
`timescale 1ns / 1ps
`include "keyframe_curve_evaluator_assert.svh"
module kfe_checker import kfe_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      i_in_ready,
    input t_in_item  i_in_data,
    input logic      i_out_valid,
    input logic      i_out_ready,
    input t_out_item i_out_data
);
    `KFE_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_data))
    `KFE_ASSERT_IMP(a_past_no_sat, i_clk, i_rst_n, i_out_valid && i_out_data.past_end, !i_out_data.saturated)
    `KFE_ASSERT_IMP(a_sat_limit, i_clk, i_rst_n, i_out_valid && i_out_data.saturated, i_out_data.curve_value == 32'sh7FFF_FFFF || i_out_data.curve_value == 32'sh8000_0000)
    `KFE_ASSERT_NXT(a_eval_busy, i_clk, i_rst_n, i_in_valid && i_in_ready && (i_in_data.cmd == CMD_EVAL), !i_in_ready)
endmodule

bind keyframe_curve_evaluator kfe_checker u_kfe_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_in_data   (i_in.data),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_data  (o_out.data)
);

>>> test/keyframe_curve_evaluator_test.sv
// Testbench: keyframe curve evaluator driven through its channels and checked against a predictor
`timescale 1ns / 1ps
module keyframe_curve_evaluator_test;
    import kfe_pkg::*;

    localparam logic [1:0] KIND_RESERVED = 2'd3;
    localparam int         SETTLE_CYCLES = 120;
    localparam int         CYCLE_LIMIT   = 1000000;
    localparam int         Q_MAX         = 32'h7fffffff;
    localparam int         Q_MIN         = 32'h80000000;

    class kfe_scoreboard;
        t_key      keys [MAX_KEYS];
        logic [5:0] keys_in_use;
        t_out_item expected_q [$];
        int        failures;

        function new();
            keys_in_use = 6'd1;
            failures    = 0;
        endfunction

        function void note_input(t_in_item it);
            int         n;
            int         li;
            int         ri;
            bit         found;
            longint     q;
            longint     tl;
            longint     tr;
            longint     t;
            longint     lv;
            longint     d;
            longint     res;
            longint     u;
            longint     a;
            longint     b;
            longint     h;
            longint     w;
            logic [1:0] kind;
            t_out_item  r;
            if (it.cmd == CMD_WRITE) begin
                keys[it.key_slot] = '{it.key_time, it.key_kind, it.key_value,
                                      it.key_slope_in, it.key_slope_out};
                return;
            end
            q     = longint'($signed(it.query_time));
            n     = keys_in_use;
            n     = (n < 1) ? 1 : (n > MAX_KEYS) ? MAX_KEYS : n;
            found = 0;
            li    = 0;
            ri    = 0;
            t     = 0;
            for (int i = 0; i < n; i++) begin
                if (longint'($signed(keys[i].key_time)) >= q) begin
                    ri    = i;
                    li    = (longint'($signed(keys[i].key_time)) == q || i == 0) ? i : i - 1;
                    found = 1;
                    break;
                end
            end
            if (!found) begin
                r.curve_value = keys[0].key_value;
                r.past_end    = 1'b1;
                r.saturated   = 1'b0;
                expected_q.push_back(r);
                return;
            end
            if (li != ri) begin
                tl = longint'($signed(keys[li].key_time));
                tr = longint'($signed(keys[ri].key_time));
                t  = ((q - tl) <<< FRAC_BITS) / (tr - tl);
            end
            lv   = longint'($signed(keys[li].key_value));
            d    = longint'($signed(keys[ri].key_value)) - lv;
            kind = keys[li].key_kind;
            res  = lv;
            if (kind inside {KIND_LINEAR, KIND_CUBIC}) begin
                res = lv + ((d * t) >>> FRAC_BITS);
                if (kind == KIND_CUBIC) begin
                    u   = (longint'(1) <<< FRAC_BITS) - t;
                    a   = longint'($signed(keys[li].key_slope_in)) - d;
                    b   = d - longint'($signed(keys[li].key_slope_out));
                    h   = (a * u + b * t) >>> FRAC_BITS;
                    w   = (t * u) >>> FRAC_BITS;
                    res = res + ((h * w) >>> FRAC_BITS);
                end
            end
            r.saturated = 1'b0;
            if (res > longint'(Q_MAX)) begin
                res         = Q_MAX;
                r.saturated = 1'b1;
            end
            if (res < longint'(Q_MIN)) begin
                res         = Q_MIN;
                r.saturated = 1'b1;
            end
            r.curve_value = res[31:0];
            r.past_end    = 1'b0;
            expected_q.push_back(r);
        endfunction

        function void check_result(t_out_item got);
            t_out_item exp_r;
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                failures++;
                return;
            end
            exp_r = expected_q.pop_front();
            if (got.curve_value !== exp_r.curve_value) begin
                $display("%0t: curve_value expected %h actual %h", $time,
                         exp_r.curve_value, got.curve_value);
                failures++;
            end
            if (got.past_end !== exp_r.past_end) begin
                $display("%0t: past_end expected %b actual %b", $time,
                         exp_r.past_end, got.past_end);
                failures++;
            end
            if (got.saturated !== exp_r.saturated) begin
                $display("%0t: saturated expected %b actual %b", $time,
                         exp_r.saturated, got.saturated);
                failures++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    kfe_in_if  in_ch ();
    kfe_out_if out_ch ();
    kfe_cfg_if cfg_ch ();

    keyframe_curve_evaluator u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source),
        .i_cfg   (cfg_ch.sink)
    );

    kfe_scoreboard curve_sb = new();
    int            send_idle_pct;
    int            recv_stall_pct;
    int            hold_request;
    int            hold_seen;
    int            hold_left;
    int            cycle_count;
    longint        timeline_base;
    longint        timeline_step;

    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (hold_request != hold_seen) begin
            hold_left = hold_request;
            hold_seen = hold_request;
        end
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left    = hold_left - 1;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (in_ch.valid && in_ch.ready) begin
                curve_sb.note_input(in_ch.data);
            end
            if (out_ch.valid && out_ch.ready) begin
                curve_sb.check_result(out_ch.data);
            end
            if (cfg_ch.valid && cfg_ch.ready) begin
                curve_sb.keys_in_use = cfg_ch.data;
            end
        end
    end

    task automatic send_item(input t_in_item it);
        if ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < send_idle_pct) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= it;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
    endtask

    task automatic write_key(input int slot, input int tm, input logic [1:0] kind,
                             input int val, input int s_in, input int s_out);
        t_in_item it;
        it               = '0;
        it.cmd           = CMD_WRITE;
        it.key_slot      = slot[4:0];
        it.key_time      = tm;
        it.key_kind      = kind;
        it.key_value     = val;
        it.key_slope_in  = s_in;
        it.key_slope_out = s_out;
        it.query_time    = $urandom;
        send_item(it);
    endtask

    task automatic evaluate(input int qt);
        t_in_item it;
        it            = '0;
        it.cmd        = CMD_EVAL;
        it.key_slot   = 5'($urandom);
        it.key_time   = $urandom;
        it.key_kind   = 2'($urandom);
        it.key_value  = $urandom;
        it.query_time = qt;
        send_item(it);
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (curve_sb.expected_q.size() > 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_config(input logic [5:0] v);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= v;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        cfg_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic int rand_field();
        case ($urandom_range(3))
            0: return $urandom;
            1: return $urandom_range(Q_MAX);
            2: return $signed($urandom_range(2 ** 20)) - (2 ** 19);
            default: return $urandom_range(1) ? Q_MAX : Q_MIN;
        endcase
    endfunction

    function automatic int timeline_time(input int slot);
        return int'(timeline_base + slot * timeline_step);
    endfunction

    task automatic write_timeline_key(input int slot);
        int tm;
        tm = ($urandom_range(9) == 0) ? $urandom : timeline_time(slot);
        write_key(slot, tm, 2'($urandom_range(3)), rand_field(), rand_field(), rand_field());
    endtask

    task automatic random_phase(input logic [5:0] cfg_value, input int idle_pct,
                                input int stall_pct, input int item_count);
        int n;
        int slot;
        int sent;
        n              = (cfg_value < 1) ? 1 : (cfg_value > MAX_KEYS) ? MAX_KEYS : cfg_value;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        write_config(cfg_value);
        timeline_base = longint'($signed($urandom)) >>> 2;
        timeline_step = $urandom_range(1, 2 ** $urandom_range(1, 24));
        for (int i = 0; i < MAX_KEYS; i++) write_timeline_key(i);
        sent = 0;
        while (sent < item_count) begin
            repeat ($urandom_range(0, 3)) begin
                write_timeline_key($urandom_range(MAX_KEYS - 1));
                sent++;
            end
            repeat ($urandom_range(3, 8)) begin
                slot = $urandom_range(n - 1);
                case ($urandom_range(5))
                    0: evaluate(timeline_time(slot));
                    1: evaluate(timeline_time(slot) - $urandom_range(1, timeline_step));
                    2: evaluate(timeline_time(0) - $urandom_range(1, 1000));
                    3: evaluate(timeline_time(n - 1) + $urandom_range(1, 1000));
                    default: evaluate($urandom);
                endcase
                sent++;
            end
        end
        drain();
    endtask

    initial begin
        hold_request   = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        i_rst_n        = 1'b0;
        in_ch.valid    = 1'b0;
        in_ch.data     = '0;
        cfg_ch.valid   = 1'b0;
        cfg_ch.data    = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        write_key(0, Q_MIN, KIND_CUBIC, Q_MAX, Q_MIN, Q_MAX);
        evaluate(Q_MIN);
        evaluate(Q_MAX);
        drain();
        write_config(6'd2);
        write_key(1, Q_MAX, KIND_LINEAR, Q_MIN, Q_MAX, Q_MIN);
        evaluate(Q_MIN);
        evaluate(0);
        evaluate(Q_MAX);
        write_key(1, 100, KIND_CUBIC, Q_MIN, 0, 0);
        evaluate(200);
        write_key(0, 0, KIND_CUBIC, 0, Q_MAX, Q_MIN);
        evaluate(50);
        write_key(0, 0, KIND_CONST, 7, 0, 0);
        evaluate(50);
        write_key(0, 0, KIND_LINEAR, Q_MAX, 0, 0);
        evaluate(99);
        write_key(0, 0, KIND_RESERVED, -5, 0, 0);
        evaluate(1);
        write_key(0, 10, KIND_LINEAR, 3, 0, 0);
        evaluate(5);
        write_key(31, -1, KIND_CUBIC, 0, 0, 0);
        drain();

        random_phase(6'd32, 0, 0, 50);
        random_phase(6'd0, 47, 0, 50);
        random_phase(6'd63, 0, 47, 50);
        random_phase(6'($urandom_range(2, 31)), 38, 38, 50);

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        write_config(6'd32);
        hold_request = 400;
        repeat (20) evaluate($urandom);
        drain();

        random_phase(6'd1, 38, 38, 30);
        random_phase(6'($urandom_range(2, 31)), 0, 0, 40);

        if (curve_sb.failures == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule
